[sv/sorted_segment_mean_core_defines.svh]
// assertion macros for the sorted segment mean core
// used by the top level only, needs nothing else
`ifndef SORTED_SEGMENT_MEAN_CORE_DEFINES_SVH
`define SORTED_SEGMENT_MEAN_CORE_DEFINES_SVH

// same-cycle implication under reset
`define SSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define SSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ssm_pkg.sv]
// shared types and constants for the sorted segment mean core
// no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int VALUE_W = 32;
  localparam int SEG_W   = 16;
  localparam int COL_W   = 6;
  localparam int SUM_W   = 48;
  localparam int COUNT_W = 17;
  localparam int RW_W    = 7;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(SUM_W - 1);
  localparam logic [VALUE_W-1:0] MEAN_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] MEAN_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_EMIT_RD,
    ST_EMIT_DIV,
    ST_EMIT_WAIT
  } state_t;

endpackage

[sv/sorted_segment_mean_core.sv]
// sorted segment mean core: per-column running sums, means emitted on segment close
// an element that closes nothing is accepted, then accumulated; s_tready is low meanwhile
// a close emits eff_width beats: ram read, 48-step bit-serial divide, load, held on stall
// an advancing element is summed after the close it starts, a final one before its close
// rst is synchronous: control state and per-column valid bits clear at once, row_width to 1
// no clearing pass over the sum ram; an entry without its valid bit reads as zero
`timescale 1ns / 1ps

module sorted_segment_mean_core #(
  parameter int MAX_ROW_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // value[31:0], segment_id[47:32]
  input  logic        s_tlast,   // final_row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // segment_index[15:0], column[21:16], mean[53:22], zero pad
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // row_width
);

  `include "sorted_segment_mean_core_defines.svh"

  localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam logic [ssm_pkg::RW_W-1:0] MAX_W = ssm_pkg::RW_W'(MAX_ROW_WIDTH);

  ssm_pkg::state_t state, state_next;

  logic [ssm_pkg::RW_W-1:0]    row_width;
  logic [ssm_pkg::RW_W-1:0]    eff_width;
  logic [ssm_pkg::RW_W-1:0]    w_last;
  logic [ssm_pkg::VALUE_W-1:0] in_value;
  logic                        in_final;
  logic [CW-1:0]               col_pos;
  logic [CW-1:0]               col_idx;
  logic [ssm_pkg::SEG_W-1:0]   cur_seg;
  logic [ssm_pkg::COUNT_W-1:0] row_count;
  logic [MAX_ROW_WIDTH-1:0]    valid;
  logic                        close_final;

  logic                        out_valid;
  logic [ssm_pkg::SEG_W-1:0]   out_seg;
  logic [ssm_pkg::COL_W-1:0]   out_col;
  logic [ssm_pkg::VALUE_W-1:0] out_mean;
  logic                        out_last;

  logic                        accept;
  logic                        adv_hit;
  logic                        row_end;
  logic                        col_last;
  logic                        out_free;
  logic                        out_load;
  logic                        ram_we;
  logic [CW-1:0]               ram_raddr;
  logic [ssm_pkg::SUM_W-1:0]   ram_rdata;
  logic [ssm_pkg::SUM_W-1:0]   acc_sum;
  logic [ssm_pkg::SUM_W-1:0]   div_dividend;
  logic                        div_start;
  logic                        div_done;
  logic [ssm_pkg::VALUE_W-1:0] div_quotient;

  // effective row width, out-of-range values clamp
  always_comb begin
    if (row_width == '0) begin
      eff_width = ssm_pkg::RW_W'(1);
    end else if (row_width > MAX_W) begin
      eff_width = MAX_W;
    end else begin
      eff_width = row_width;
    end
  end

  assign w_last   = eff_width - 1'b1;
  assign row_end  = ssm_pkg::RW_W'(col_pos) >= w_last;
  assign col_last = ssm_pkg::RW_W'(col_idx) == w_last;
  assign accept   = s_tvalid && s_tready;
  assign adv_hit  = (col_pos == '0) &&
                    ({1'b0, s_tdata[47:32]} == ({1'b0, cur_seg} + 1'b1));
  assign out_free = !out_valid || m_tready;
  assign out_load = (state == ssm_pkg::ST_EMIT_WAIT) && div_done && out_free;

  assign acc_sum      = (valid[col_pos] ? ram_rdata : '0) +
                        {{(ssm_pkg::SUM_W-ssm_pkg::VALUE_W){in_value[ssm_pkg::VALUE_W-1]}},
                         in_value};
  assign div_dividend = valid[col_idx] ? ram_rdata : '0;

  ssm_ram #(
    .WIDTH (ssm_pkg::SUM_W),
    .DEPTH (MAX_ROW_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_pos),
    .wdata (acc_sum),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ssm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (row_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ssm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = adv_hit ? ssm_pkg::ST_EMIT_RD : ssm_pkg::ST_ACC;
        end
      end
      ssm_pkg::ST_ACC: begin
        state_next = (row_end && in_final) ? ssm_pkg::ST_EMIT_RD : ssm_pkg::ST_IDLE;
      end
      ssm_pkg::ST_EMIT_RD: begin
        state_next = ssm_pkg::ST_EMIT_DIV;
      end
      ssm_pkg::ST_EMIT_DIV: begin
        state_next = ssm_pkg::ST_EMIT_WAIT;
      end
      ssm_pkg::ST_EMIT_WAIT: begin
        if (out_load) begin
          if (!col_last) begin
            state_next = ssm_pkg::ST_EMIT_RD;
          end else begin
            state_next = close_final ? ssm_pkg::ST_IDLE : ssm_pkg::ST_ACC;
          end
        end
      end
      default: state_next = ssm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = col_pos;
    div_start = 1'b0;
    unique case (state)
      ssm_pkg::ST_IDLE:      s_tready  = 1'b1;
      ssm_pkg::ST_ACC:       ram_we    = 1'b1;
      ssm_pkg::ST_EMIT_RD:   ram_raddr = col_idx;
      ssm_pkg::ST_EMIT_DIV:  div_start = 1'b1;
      ssm_pkg::ST_EMIT_WAIT: ram_raddr = col_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ssm_pkg::ST_IDLE;
      row_width   <= ssm_pkg::RW_W'(1);
      col_pos     <= '0;
      col_idx     <= '0;
      cur_seg     <= '0;
      row_count   <= '0;
      valid       <= '0;
      close_final <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        row_width <= cfg_data;
      end
      if (accept && adv_hit) begin
        col_idx     <= '0;
        close_final <= 1'b0;
      end
      if (state == ssm_pkg::ST_ACC) begin
        valid[col_pos] <= 1'b1;
        if (row_end) begin
          col_pos <= '0;
          if (row_count != ssm_pkg::COUNT_MAX) begin
            row_count <= row_count + 1'b1;
          end
          if (in_final) begin
            col_idx     <= '0;
            close_final <= 1'b1;
          end
        end else begin
          col_pos <= col_pos + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
        if (col_last) begin
          valid     <= '0;
          row_count <= '0;
          cur_seg   <= close_final ? '0 : cur_seg + 1'b1;
        end else begin
          col_idx <= col_idx + 1'b1;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_value <= s_tdata[31:0];
      in_final <= s_tlast;
    end
    if (out_load) begin
      out_seg  <= cur_seg;
      out_col  <= ssm_pkg::COL_W'(col_idx);
      out_mean <= div_quotient;
      out_last <= col_last;
    end
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {2'b00, out_mean, out_col, out_seg};
  assign m_tlast   = out_last;

  `SSM_ASSERT_NEXT(a_adv_starts_col0, clk, rst,
    accept && adv_hit,
    state == ssm_pkg::ST_EMIT_RD && col_idx == '0 && !close_final,
    "advance close does not start at column 0")

  `SSM_ASSERT_NEXT(a_close_clears, clk, rst,
    out_load && col_last,
    valid == '0 && row_count == '0,
    "segment close did not clear sums and count")

  `SSM_ASSERT_NEXT(a_div_restarts, clk, rst,
    div_start,
    !div_done && state == ssm_pkg::ST_EMIT_WAIT,
    "divider result seen before the division ran")

  `SSM_ASSERT_NOW(a_no_accept_while_emit, clk, rst,
    state != ssm_pkg::ST_IDLE,
    !s_tready,
    "input accepted while a segment is being emitted")

endmodule

[sv/ssm_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ssm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ssm_div.sv]
// bit-serial restoring divider: signed 48-bit sum over unsigned 17-bit count
// one quotient bit per cycle, saturates to 32 bits; uses ssm_pkg
`timescale 1ns / 1ps

module ssm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ssm_pkg::SUM_W-1:0]    dividend,
  input  logic [ssm_pkg::COUNT_W-1:0]  divisor,
  output logic                         done,
  output logic [ssm_pkg::VALUE_W-1:0]  quotient
);

  logic                          busy;
  logic                          neg;
  logic                          zero_div;
  logic [ssm_pkg::SUM_W-1:0]     mag;
  logic [ssm_pkg::COUNT_W-1:0]   rem;
  logic [ssm_pkg::COUNT_W-1:0]   dsr;
  logic [ssm_pkg::STEP_W-1:0]    step;
  logic [ssm_pkg::COUNT_W:0]     shifted;
  logic [ssm_pkg::COUNT_W+1:0]   diff;
  logic                          take;
  logic                          over_pos;
  logic                          over_neg;

  assign shifted = {rem, mag[ssm_pkg::SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign take    = ~diff[ssm_pkg::COUNT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      neg      <= dividend[ssm_pkg::SUM_W-1];
      zero_div <= (divisor == '0);
      dsr      <= divisor;
      mag      <= dividend[ssm_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem      <= '0;
      step     <= ssm_pkg::STEP_LAST;
    end else if (busy) begin
      rem  <= take ? diff[ssm_pkg::COUNT_W-1:0] : shifted[ssm_pkg::COUNT_W-1:0];
      mag  <= {mag[ssm_pkg::SUM_W-2:0], take};
      step <= step - 1'b1;
    end
  end

  assign over_pos = |mag[ssm_pkg::SUM_W-1:ssm_pkg::VALUE_W-1];
  assign over_neg = (|mag[ssm_pkg::SUM_W-1:ssm_pkg::VALUE_W]) ||
                    (mag[ssm_pkg::VALUE_W-1] && (|mag[ssm_pkg::VALUE_W-2:0]));

  always_comb begin
    if (zero_div) begin
      quotient = '0;
    end else if (neg) begin
      quotient = over_neg ? ssm_pkg::MEAN_MIN
                          : (~mag[ssm_pkg::VALUE_W-1:0] + 1'b1);
    end else begin
      quotient = over_pos ? ssm_pkg::MEAN_MAX : mag[ssm_pkg::VALUE_W-1:0];
    end
  end

endmodule

[bench/ssm_mean_checker.sv]
// checker for the sorted segment mean core: follows every config, input and result beat,
// predicts the column means of each closed segment and compares result beats in order
// depends on ssm_pkg for widths and the row count ceiling
`timescale 1ns / 1ps

module ssm_mean_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // value[31:0], segment_id[47:32]
  input  logic        s_tlast,   // final_row
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // segment_index[15:0], column[21:16], mean[53:22], zero pad
  input  logic        m_tlast,   // last
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,  // row_width
  output int          mismatches,
  output int          pending_means
);

  import ssm_pkg::*;

  typedef struct packed {
    logic [SEG_W-1:0]   seg;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] mean;
    logic               last;
  } mean_beat_t;

  mean_beat_t         expected_means[$];
  logic [SUM_W-1:0]   col_sum [64];
  logic [COUNT_W-1:0] rows_seen;
  logic [SEG_W-1:0]   seg_now;
  logic [COL_W-1:0]   col_now;
  logic [RW_W-1:0]    width_reg;

  function automatic int active_width();
    if (width_reg == '0) return 1;
    if (width_reg > 7'd64) return 64;
    return int'(width_reg);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_sums();
    for (int i = 0; i < 64; i++) col_sum[i] = '0;
    rows_seen = '0;
  endtask

  // one mean beat per column of the current width
  task automatic close_segment();
    int         w;
    longint     q;
    mean_beat_t b;
    w = active_width();
    for (int j = 0; j < w; j++) begin
      q = 0;
      if (rows_seen != '0) begin
        q = longint'($signed(col_sum[j])) / longint'({1'b0, rows_seen});
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      b.seg  = seg_now;
      b.col  = COL_W'(j);
      b.mean = q[VALUE_W-1:0];
      b.last = (j == w - 1);
      expected_means.push_back(b);
    end
  endtask

  task automatic absorb_element(input logic [VALUE_W-1:0] value, input logic [SEG_W-1:0] id,
                                input logic fin);
    int   w;
    int   pos;
    logic row_end;
    w       = active_width();
    pos     = int'(col_now);
    row_end = (pos >= w - 1);
    if (pos == 0 && {1'b0, id} == {1'b0, seg_now} + 17'd1) begin
      close_segment();
      clear_sums();
      seg_now = seg_now + 1'b1;
    end
    col_sum[pos] = col_sum[pos] + {{(SUM_W-VALUE_W){value[VALUE_W-1]}}, value};
    if (row_end) begin
      if (rows_seen != COUNT_MAX) rows_seen = rows_seen + 1'b1;
      col_now = '0;
      if (fin) begin
        close_segment();
        clear_sums();
        seg_now = '0;
      end
    end else begin
      col_now = col_now + 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    mean_beat_t got;
    mean_beat_t want;
    if (rst) begin
      clear_sums();
      seg_now    = '0;
      col_now    = '0;
      width_reg  = RW_W'(1);
      mismatches = 0;
      expected_means.delete();
    end else begin
      if (cfg_valid && cfg_ready) width_reg = cfg_data;
      if (s_tvalid && s_tready) absorb_element(s_tdata[31:0], s_tdata[47:32], s_tlast);
      if (m_tvalid && m_tready) begin
        got.seg  = m_tdata[15:0];
        got.col  = m_tdata[21:16];
        got.mean = m_tdata[53:22];
        got.last = m_tlast;
        if (expected_means.size() == 0) begin
          report_mismatch("result beat with nothing pending", 64'(m_tdata), '0);
        end else begin
          want = expected_means.pop_front();
          if (got.seg !== want.seg) report_mismatch("segment_index", 64'(got.seg), 64'(want.seg));
          if (got.col !== want.col) report_mismatch("column", 64'(got.col), 64'(want.col));
          if (got.mean !== want.mean) report_mismatch("mean", 64'(got.mean), 64'(want.mean));
          if (got.last !== want.last) report_mismatch("last", 64'(got.last), 64'(want.last));
        end
      end
    end
    pending_means = expected_means.size();
  end

endmodule

[bench/testbench.sv]
// top of the sorted segment mean core bench: clock, reset, row stimulus, config writes,
// random stalls on both streams and the final verdict
// depends on ssm_pkg, sorted_segment_mean_core and ssm_mean_checker
`timescale 1ns / 1ps

module testbench;

  import ssm_pkg::*;

  localparam int CYCLE_LIMIT  = 6000000;
  localparam int RANDOM_ITEMS = 260;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data  = 7'd1;

  int mismatches;
  int pending_means;

  bit               src_idle_on  = 1'b0;
  bit               sink_idle_on = 1'b0;
  int               stall_left   = 0;
  int               cycles       = 0;
  int               items_sent   = 0;
  int               pos_guess    = 0;
  logic [SEG_W-1:0] seg_guess    = '0;
  logic [RW_W-1:0]  width_now    = RW_W'(1);

  always #5 clk = ~clk;

  sorted_segment_mean_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ssm_mean_checker mean_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_means (pending_means)
  );

  // output stalls in bursts, each begun with a one in eight chance while sink idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_segment_mean_core verification failed");
      $finish;
    end
  end

  function automatic int eff_width(input logic [RW_W-1:0] w);
    if (w == '0) return 1;
    if (w > 7'd64) return 64;
    return int'(w);
  endfunction

  function automatic logic [RW_W-1:0] pick_width();
    case ($urandom_range(0, 15))
      0:       return RW_W'(0);
      1:       return RW_W'(64);
      2:       return RW_W'(127);
      3:       return RW_W'(65);
      4:       return RW_W'($urandom_range(0, 127));
      default: return RW_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return '0;
      3:       return '1;
      4, 5:    return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_element(input logic [VALUE_W-1:0] value, input logic [SEG_W-1:0] id,
                              input logic fin);
    int gap;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap      = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {id, value};
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    // track where the row stands so that ids are picked on row starts
    if (pos_guess == 0 && {1'b0, id} == {1'b0, seg_guess} + 17'd1) seg_guess = seg_guess + 1'b1;
    if (pos_guess >= eff_width(width_now) - 1) begin
      pos_guess = 0;
      if (fin) seg_guess = '0;
    end else begin
      pos_guess++;
    end
  endtask

  task automatic write_width(input logic [RW_W-1:0] w);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_means != 0);
    repeat (64) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_now = w;
  endtask

  // mostly stays on or advances the segment, now and then a stray id
  task automatic send_row(input bit close_seq);
    int               w;
    logic [SEG_W-1:0] id;
    logic             end_el;
    w = eff_width(width_now);
    do begin
      if (pos_guess == 0) begin
        case ($urandom_range(0, 9))
          0:       id = 16'($urandom);
          1, 2:    id = seg_guess + 1'b1;
          default: id = seg_guess;
        endcase
      end else begin
        id = 16'($urandom);
      end
      end_el = (pos_guess >= w - 1);
      send_element(pick_value(), id, end_el ? close_seq : 1'($urandom_range(0, 1)));
    end while (!end_el);
  endtask

  task automatic send_partial_row();
    int w;
    int n;
    w = eff_width(width_now);
    n = $urandom_range(1, w - 1);
    while (n > 0 && pos_guess < w - 1) begin
      send_element(pick_value(), pos_guess == 0 ? seg_guess : 16'($urandom),
                   1'($urandom_range(0, 1)));
      n--;
    end
  endtask

  initial begin : stimulus
    int              rows;
    int              w_eff;
    int              phase;
    int              random_start;
    bit              tail;
    logic [RW_W-1:0] wsel;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // row width 1 out of reset
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_element(32'h7fffffff, 16'd0, 1'b0);
    send_element(32'h80000000, 16'hffff, 1'b0);  // skip ahead keeps accumulating
    send_element(32'hffffffff, 16'd1, 1'b0);     // advance close
    send_element(32'h00000000, 16'd2, 1'b1);     // advance and final close on one beat
    send_element(32'h00003039, 16'd1, 1'b0);     // closes a segment with no rows
    send_element(32'hfffffffb, 16'd1, 1'b1);

    // ids and final flags off the row start are ignored
    write_width(RW_W'(3));
    send_element(32'h7fffffff, 16'd0, 1'b0);
    send_element(32'h12345678, 16'hffff, 1'b1);
    send_element(32'h80000001, 16'd1, 1'b0);
    send_element(32'h80000000, 16'd0, 1'b0);
    send_element(32'h80000000, 16'd1, 1'b0);
    send_element(32'h80000000, 16'd0, 1'b0);
    send_element(32'h00000001, 16'd1, 1'b0);
    send_element(32'h00000002, 16'd0, 1'b0);

    // narrower width while mid-row ends the row on the next beat
    src_idle_on = 1'b0;
    write_width(RW_W'(2));
    send_element(32'h00000007, 16'd0, 1'b1);

    // width 0 behaves as 1
    sink_idle_on = 1'b0;
    write_width(RW_W'(0));
    send_element(32'hffff0000, 16'd0, 1'b0);
    send_element(32'h00010000, 16'd1, 1'b1);

    phase        = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case (phase)
        0:       wsel = RW_W'(127);
        1:       wsel = RW_W'(64);
        default: wsel = pick_width();
      endcase
      tail         = (items_sent - random_start) > RANDOM_ITEMS - 50;
      src_idle_on  = !tail && $urandom_range(0, 2) != 0;
      sink_idle_on = !tail && $urandom_range(0, 2) != 0;
      write_width(wsel);
      w_eff = eff_width(wsel);
      rows  = (w_eff > 16) ? 1 : $urandom_range(2, 12);
      for (int r = 0; r < rows; r++) send_row(r == rows - 1 && $urandom_range(0, 2) != 0);
      if (w_eff > 1 && $urandom_range(0, 3) == 0) send_partial_row();
      phase++;
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_means != 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_segment_mean_core verification clean");
    end else begin
      $display("sorted_segment_mean_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ssm_pkg.sv
sv/ssm_ram.sv
sv/ssm_div.sv
sv/sorted_segment_mean_core.sv
bench/ssm_mean_checker.sv
bench/testbench.sv
